### rtl/fft_pkg.sv
package fft_pkg;

  localparam int LOG2_MAX_POINTS = 6;
  localparam int SAMPLE_BITS     = 24;
  localparam int TWIDDLE_BITS    = 16;
  localparam int OUT_BITS        = 24;
  localparam int IN_BITS         = 16;
  localparam int CFG_ADDR_BITS   = 1;
  localparam int CFG_DATA_BITS   = 3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_DIRECTION   = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LOG2_POINTS = 1'b1;

  typedef struct packed {
    logic signed [IN_BITS-1:0] re_in;
    logic signed [IN_BITS-1:0] im_in;
  } fft_in_t;

  typedef struct packed {
    logic [5:0]                 point_index;
    logic signed [OUT_BITS-1:0] re_out;
    logic signed [OUT_BITS-1:0] im_out;
    logic                       last_point;
  } fft_out_t;

  // cos(2*pi*k/64) in Q2.30, k = 0..16
  function automatic logic [31:0] quarter_cos(input logic [4:0] k);
    logic [31:0] v;
    begin
      case (k)
        5'd0:  v = 32'd1073741824;
        5'd1:  v = 32'd1068571464;
        5'd2:  v = 32'd1053110176;
        5'd3:  v = 32'd1027506862;
        5'd4:  v = 32'd992008094;
        5'd5:  v = 32'd946955747;
        5'd6:  v = 32'd892783698;
        5'd7:  v = 32'd830013654;
        5'd8:  v = 32'd759250125;
        5'd9:  v = 32'd681174602;
        5'd10: v = 32'd596538995;
        5'd11: v = 32'd506158392;
        5'd12: v = 32'd410903207;
        5'd13: v = 32'd311690799;
        5'd14: v = 32'd209476638;
        5'd15: v = 32'd105245103;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

  // Q2.30 magnitude to Q1.(TW-1), round half up, saturate positive side
  function automatic logic signed [TWIDDLE_BITS:0] tw_round(input logic [31:0] v);
    logic [32:0] r;
    logic [32:0] hi;
    begin
      r  = ({1'b0, v} + (33'd1 << (30 - TWIDDLE_BITS))) >> (31 - TWIDDLE_BITS);
      hi = (33'd1 << (TWIDDLE_BITS - 1)) - 33'd1;
      if (r > hi) r = hi;
      return $signed(r[TWIDDLE_BITS:0]);
    end
  endfunction

endpackage

### rtl/radix2_fft_in_place.sv
// Radix-2 decimation-in-time FFT, 2..64 points, in-place storage.
// Input: start_i with sample_i (re_in, im_in); a sample is taken on each edge
// where start_i is high and busy_o is low. Samples land at bit-reversed
// addresses. The sample that completes N = 2^log2_points samples starts the
// transform; busy_o stays high until all N results have gone out.
// Output: done_o strobes one result per cycle (point_index 0..N-1,
// last_point on N-1). The receiver cannot stall; results are not held.
// Sequence: one complex multiply-add unit serves every butterfly of every
// stage in the steps read, multiply, and round and write back both points;
// then an inverse-only pass scales each point by 1/N, and a readout pass
// sends the points out. Loading is one sample per cycle.
// Config: cfg_we_i, cfg_addr_i (0 direction, 1 log2_points), cfg_wdata_i;
// write only while idle. Reset: direction 0, log2_points 6, load count 0;
// the sample stores are not cleared and hold garbage until written.
module radix2_fft_in_place
  import fft_pkg::*;
#(
  parameter int LogMax = LOG2_MAX_POINTS,
  parameter int SampleBits = SAMPLE_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  fft_in_t                  sample_i,
  output logic                     busy_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output logic                     done_o,
  output fft_out_t                 result_o
);

  localparam int TwBits = TWIDDLE_BITS;
  localparam int Depth = 1 << LogMax;
  localparam int AW = LogMax;
  localparam int SW = SampleBits;
  localparam int PW = SW + TwBits + 2;

  typedef enum logic [2:0] {
    ST_LOAD, ST_RD, ST_MUL, ST_WR, ST_SCALE, ST_OUT
  } state_e;

  state_e state_q;
  logic              dir_q;
  logic [2:0]        l2_q;
  logic [AW:0]       cnt_q;
  logic [2:0]        stage_q;
  logic [AW-1:0]     grp_q;    // butterfly index within stage, 0..N/2-1
  logic [AW-1:0]     idx_q;    // scale / output index

  logic signed [SW-1:0] re_mem [Depth];
  logic signed [SW-1:0] im_mem [Depth];

  logic signed [SW-1:0] ar_q, ai_q, xr_q, xi_q;
  logic signed [TwBits-1:0] wr_q, wi_q;
  logic signed [PW-1:0] tr_q, ti_q;
  logic [AW-1:0] p_q, q_q;

  // effective length
  logic [2:0] m;
  always_comb begin
    m = l2_q;
    if (m < 3'd1) m = 3'd1;
    if ({29'd0, m} > 32'(LogMax)) m = 3'(LogMax);
  end
  logic [AW:0] n_pts;
  assign n_pts = (AW+1)'(1) << m;

  // bit-reversed load address
  logic [AW-1:0] lidx, laddr;
  assign lidx = cnt_q[AW-1:0] & AW'(n_pts - 1);
  always_comb begin
    laddr = '0;
    for (int b = 0; b < AW; b++) begin
      if (b < int'(m)) laddr[int'(m) - 1 - b] = lidx[b];
    end
  end

  // butterfly addressing: grp = block*half + i
  logic [AW-1:0] half, i_in, blk, qa, pa;
  logic [4:0] tk;
  assign half = AW'(1) << (stage_q - 3'd1);
  assign i_in = grp_q & (half - AW'(1));
  assign blk  = (grp_q >> (stage_q - 3'd1));
  assign qa   = (blk << stage_q) | i_in;
  assign pa   = qa + half;
  assign tk   = 5'(6'(i_in) << (3'd6 - stage_q));

  // twiddle lookup
  logic signed [TwBits:0] cw, sw_;
  always_comb begin
    if (tk <= 5'd16) begin
      cw  = tw_round(quarter_cos(tk));
      sw_ = tw_round(quarter_cos(5'd16 - tk));
    end else begin
      cw  = -tw_round(quarter_cos(5'(6'd32 - 6'(tk))));
      sw_ = tw_round(quarter_cos(tk - 5'd16));
    end
  end

  // round products, then saturated add/sub
  localparam logic signed [PW-1:0] HalfLsb = PW'(1) <<< (TwBits - 2);
  logic signed [PW-1:0] trr, tir;
  assign trr = (tr_q + HalfLsb) >>> (TwBits - 1);
  assign tir = (ti_q + HalfLsb) >>> (TwBits - 1);

  function automatic logic signed [SW-1:0] sat(input logic signed [PW:0] v);
    logic signed [PW:0] hi, lo;
    begin
      hi = (PW+1)'((64'sd1 <<< (SW - 1)) - 1);
      lo = -hi - 1;
      if (v > hi) return hi[SW-1:0];
      if (v < lo) return lo[SW-1:0];
      return v[SW-1:0];
    end
  endfunction

  function automatic logic signed [OUT_BITS-1:0] osat(input logic signed [SW-1:0] v);
    logic signed [SW+OUT_BITS:0] w, hi, lo;
    begin
      w  = (SW+OUT_BITS+1)'(v);
      hi = (SW+OUT_BITS+1)'((64'sd1 <<< (OUT_BITS - 1)) - 1);
      lo = -hi - 1;
      if (w > hi) return hi[OUT_BITS-1:0];
      if (w < lo) return lo[OUT_BITS-1:0];
      return w[OUT_BITS-1:0];
    end
  endfunction

  logic signed [PW:0] sr_p, si_p, sr_q, si_q;
  assign sr_p = (PW+1)'(ar_q) - (PW+1)'(trr);
  assign si_p = (PW+1)'(ai_q) - (PW+1)'(tir);
  assign sr_q = (PW+1)'(ar_q) + (PW+1)'(trr);
  assign si_q = (PW+1)'(ai_q) + (PW+1)'(tir);

  logic last_bf;
  assign last_bf = (grp_q == AW'((n_pts >> 1) - 1));

  // share one read port between the butterfly's upper point and scale/readout
  logic [AW-1:0] ra;
  assign ra = (state_q == ST_RD) ? qa : idx_q;

  // memories: one write port each for the two butterfly outputs
  logic signed [SW-1:0] rd_r, rd_i;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && start_i) begin
      re_mem[laddr] <= SW'(sample_i.re_in);
      im_mem[laddr] <= SW'(sample_i.im_in);
    end else if (state_q == ST_WR) begin
      re_mem[p_q] <= sat(sr_p);
      im_mem[p_q] <= sat(si_p);
      re_mem[q_q] <= sat(sr_q);
      im_mem[q_q] <= sat(si_q);
    end else if (state_q == ST_SCALE) begin
      re_mem[idx_q] <= rd_r >>> m;
      im_mem[idx_q] <= rd_i >>> m;
    end
  end
  assign rd_r = re_mem[ra];
  assign rd_i = im_mem[ra];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      dir_q    <= 1'b0;
      l2_q     <= 3'd6;
      cnt_q    <= '0;
      stage_q  <= 3'd1;
      grp_q    <= '0;
      idx_q    <= '0;
      ar_q     <= '0;
      ai_q     <= '0;
      xr_q     <= '0;
      xi_q     <= '0;
      wr_q     <= '0;
      wi_q     <= '0;
      tr_q     <= '0;
      ti_q     <= '0;
      p_q      <= '0;
      q_q      <= '0;
      done_o   <= 1'b0;
      result_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_DIRECTION:   dir_q <= cfg_wdata_i[0];
          REG_LOG2_POINTS: l2_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_LOAD: begin
          if (start_i) begin
            if (cnt_q + 1'b1 >= n_pts) begin
              cnt_q   <= '0;
              stage_q <= 3'd1;
              grp_q   <= '0;
              state_q <= ST_RD;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_RD: begin
          ar_q <= rd_r;
          ai_q <= rd_i;
          xr_q <= re_mem[pa];
          xi_q <= im_mem[pa];
          p_q  <= pa;
          q_q  <= qa;
          wr_q <= TwBits'(cw);
          wi_q <= dir_q ? TwBits'(sw_) : TwBits'(-sw_);
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          tr_q <= PW'(xr_q * wr_q) - PW'(xi_q * wi_q);
          ti_q <= PW'(xi_q * wr_q) + PW'(xr_q * wi_q);
          state_q <= ST_WR;
        end
        ST_WR: begin
          state_q <= ST_RD;
          grp_q   <= grp_q + 1'b1;
          if (last_bf) begin
            grp_q <= '0;
            if (stage_q == m) begin
              idx_q   <= '0;
              state_q <= dir_q ? ST_SCALE : ST_OUT;
            end else begin
              stage_q <= stage_q + 3'd1;
            end
          end
        end
        ST_SCALE: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == AW'(n_pts - 1)) begin
            idx_q   <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          done_o <= 1'b1;
          result_o.point_index <= 6'(idx_q);
          result_o.re_out      <= osat(rd_r);
          result_o.im_out      <= osat(rd_i);
          result_o.last_point  <= (idx_q == AW'(n_pts - 1));
          idx_q <= idx_q + 1'b1;
          if (idx_q == AW'(n_pts - 1)) begin
            idx_q   <= '0;
            state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign busy_o = (state_q != ST_LOAD);

`ifndef ASSERT_OFF
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o || $past(state_q) == ST_OUT) else $error("result outside readout");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < n_pts || state_q == ST_LOAD) else $error("load count out of range");
  a_out_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.last_point |=> done_o) else $error("readout run broken");
`endif

endmodule

### tb/testbench.sv
module testbench;
  import fft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  fft_in_t                  sample_i;
  logic                     busy_o;
  logic                     cfg_we_i;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     done_o;
  fft_out_t                 result_o;

  radix2_fft_in_place u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .sample_i   (sample_i),
    .busy_o     (busy_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the transform: stores, load counter and registers
  longint   spec_re [64];
  longint   spec_im [64];
  int       spec_count;
  bit       spec_inverse;
  bit [2:0] spec_log2;
  fft_out_t expected_points[$];

  int  error_count;
  int  cycle_count;
  int  sender_idle_pct;
  bit  start_held;

  const longint QCOS[17] = '{
    1073741824, 1068571464, 1053110176, 1027506862, 992008094,
    946955747, 892783698, 830013654, 759250125, 681174602,
    596538995, 506158392, 410903207, 311690799, 209476638,
    105245103, 0
  };

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint round_down_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint cos_q30(int k);
    k = k & 31;
    return (k <= 16) ? QCOS[k] : -QCOS[32 - k];
  endfunction

  function automatic longint sin_q30(int k);
    k = k & 31;
    return (k <= 16) ? QCOS[16 - k] : QCOS[k - 16];
  endfunction

  function automatic int reverse_bits(int x, int bits);
    int r;
    r = 0;
    for (int b = 0; b < bits; b++) begin
      r = (r << 1) | (x & 1);
      x = x >> 1;
    end
    return r;
  endfunction

  // Butterfly passes over the shadow store, then 1/N scaling on inverse
  function automatic void run_butterflies(int m);
    int     n;
    int     span;
    int     half;
    int     k;
    int     p;
    int     q;
    longint wr;
    longint wi;
    longint tr;
    longint ti;
    longint ar;
    longint ai;
    n = 1 << m;
    for (int st = 1; st <= m; st++) begin
      span = 1 << st;
      half = span >> 1;
      for (int i = 0; i < half; i++) begin
        k  = i << (6 - st);
        wr = clamp(round_down_shift(cos_q30(k), 31 - TWIDDLE_BITS), TWIDDLE_BITS);
        wi = clamp(round_down_shift(sin_q30(k), 31 - TWIDDLE_BITS), TWIDDLE_BITS);
        if (!spec_inverse) wi = -wi;
        for (int j = i; j < n; j += span) begin
          p  = (j + half) & 63;
          q  = j & 63;
          tr = round_down_shift(spec_re[p] * wr - spec_im[p] * wi, TWIDDLE_BITS - 1);
          ti = round_down_shift(spec_im[p] * wr + spec_re[p] * wi, TWIDDLE_BITS - 1);
          ar = spec_re[q];
          ai = spec_im[q];
          spec_re[p] = clamp(ar - tr, SAMPLE_BITS);
          spec_im[p] = clamp(ai - ti, SAMPLE_BITS);
          spec_re[q] = clamp(ar + tr, SAMPLE_BITS);
          spec_im[q] = clamp(ai + ti, SAMPLE_BITS);
        end
      end
    end
    if (spec_inverse) begin
      for (int i = 0; i < n; i++) begin
        spec_re[i] = spec_re[i] >>> m;
        spec_im[i] = spec_im[i] >>> m;
      end
    end
  endfunction

  // Store one accepted sample; on a full frame queue the N expected points
  function automatic void predict_spectrum(fft_in_t x);
    int       m;
    int       n;
    int       addr;
    fft_out_t pt;
    m = (spec_log2 == 0) ? 1 : ((spec_log2 > 6) ? 6 : int'(spec_log2));
    n = 1 << m;
    addr = reverse_bits(spec_count & (n - 1), m);
    spec_re[addr] = longint'(x.re_in);
    spec_im[addr] = longint'(x.im_in);
    spec_count = (spec_count + 1) & 127;
    if (spec_count < n) return;
    spec_count = 0;
    run_butterflies(m);
    for (int i = 0; i < n; i++) begin
      pt.point_index = 6'(i);
      pt.re_out      = OUT_BITS'(clamp(spec_re[i], OUT_BITS));
      pt.im_out      = OUT_BITS'(clamp(spec_im[i], OUT_BITS));
      pt.last_point  = (i == n - 1);
      expected_points.push_back(pt);
    end
  endfunction

  // Compare each result beat with the oldest expected point
  always @(posedge clk_i) begin
    fft_out_t want;
    if (rst_ni && done_o) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result beat, point_index %0d", result_o.point_index);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (result_o.point_index !== want.point_index) begin
          $error("point_index expected %0d got %0d", want.point_index, result_o.point_index);
          error_count++;
        end
        if (result_o.re_out !== want.re_out) begin
          $error("re_out expected %0d got %0d", want.re_out, result_o.re_out);
          error_count++;
        end
        if (result_o.im_out !== want.im_out) begin
          $error("im_out expected %0d got %0d", want.im_out, result_o.im_out);
          error_count++;
        end
        if (result_o.last_point !== want.last_point) begin
          $error("last_point expected %0d got %0d", want.last_point, result_o.last_point);
          error_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic release_start();
    if (start_held) begin
      start_i    <= 1'b0;
      start_held = 1'b0;
    end
  endtask

  // Drive one sample beat and hold it until the block takes it
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    fft_in_t x;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      release_start();
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    x.re_in = re;
    x.im_in = im;
    start_i    <= 1'b1;
    sample_i   <= x;
    start_held = 1'b1;
    do @(posedge clk_i); while (busy_o);
    predict_spectrum(x);
  endtask

  // Stop sending, drain every expected point, let the block settle
  task automatic drain();
    release_start();
    while (expected_points.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, int value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= CFG_DATA_BITS'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DIRECTION) spec_inverse = value[0];
    else spec_log2 = 3'(value);
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'sh7fff;
      1:       return -16'sh8000;
      2:       return 16'(signed'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Extreme samples through a 2-point transform, both directions
  task automatic test_extremes();
    write_reg(REG_LOG2_POINTS, 1);
    for (int d = 0; d < 2; d++) begin
      write_reg(REG_DIRECTION, d);
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(16'sh7fff, -16'sh8000);
      send_sample(-16'sh8000, 16'sh7fff);
      drain();
    end
  endtask

  // Length code zero acts as the shortest transform
  task automatic test_zero_length();
    write_reg(REG_DIRECTION, 0);
    write_reg(REG_LOG2_POINTS, 0);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(-16'sh8000, -16'sh8000);
    drain();
  endtask

  // Grow the length after part of a frame is loaded
  task automatic test_grow_mid_load();
    write_reg(REG_LOG2_POINTS, 1);
    write_reg(REG_DIRECTION, 1);
    send_sample(16'sh1234, -16'sh0567);
    drain();
    write_reg(REG_LOG2_POINTS, 3);
    for (int i = 0; i < 7; i++) send_sample(pick_value(), pick_value());
    drain();
  endtask

  // Random frames under random settings with the given sender idling
  task automatic test_random_frames(int idle_pct, int target);
    int sent;
    int lg;
    int n;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < target) begin
      lg = $urandom_range(0, 7);
      if (lg >= 5 && $urandom_range(3) != 0) lg = $urandom_range(1, 3);
      write_reg(REG_LOG2_POINTS, lg);
      write_reg(REG_DIRECTION, $urandom_range(1));
      n = 1 << ((lg == 0) ? 1 : ((lg > 6) ? 6 : lg));
      repeat ($urandom_range(1, 3)) begin
        for (int i = 0; i < n; i++) send_sample(pick_value(), pick_value());
        sent += n;
      end
      drain();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    sample_i    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= '0;
    cfg_wdata_i <= '0;
    start_held      = 1'b0;
    sender_idle_pct = 0;
    error_count     = 0;
    cycle_count     = 0;
    spec_count      = 0;
    spec_inverse    = 1'b0;
    spec_log2       = 3'd6;
    foreach (spec_re[i]) begin
      spec_re[i] = 0;
      spec_im[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_zero_length();
    test_grow_mid_load();
    test_random_frames(29, 150);
    test_random_frames(57, 150);
    test_random_frames(0, 150);

    drain();
    repeat (20) @(posedge clk_i);
    if (expected_points.size() != 0) begin
      $error("%0d expected points never arrived", expected_points.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
